[design/mmcs_pkg.sv]
// mmcs_pkg: shared constants and types of the min/max contrast stretch block.
// Used by the divider unit and the top level; depends on nothing.
`timescale 1ns / 1ps

package mmcs_pkg;

  // frame store geometry
  localparam int MaxPixels = 131072;
  localparam int AddrW     = $clog2(MaxPixels);
  localparam int CountW    = $clog2(MaxPixels + 1);

  // pixel and product widths
  localparam int PixW = 8;
  localparam int NumW = 2 * PixW;
  localparam int StepW = $clog2(NumW);

  localparam logic [PixW-1:0] PixMax = {PixW{1'b1}};
  localparam logic [PixW-1:0] PixMin = {PixW{1'b0}};

  // request from the sequencer to the divider unit
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [PixW-1:0] den;
  } div_req_t;

  // answer from the divider unit, rounded and saturated
  typedef struct packed {
    logic            done;
    logic [PixW-1:0] result;
  } div_rsp_t;

endpackage

[design/mmcs_ram.sv]
// mmcs_ram: generic simple dual-port RAM, one write and one registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module mmcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mmcs_div.sv]
// mmcs_div: radix-2 restoring divider with round-half-even and saturation.
// Depends on mmcs_pkg for widths and the request/answer structs.
`timescale 1ns / 1ps

module mmcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmcs_pkg::div_req_t req_i,
  output mmcs_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          fin_q;
  logic [mmcs_pkg::StepW-1:0]    step_q;
  logic [mmcs_pkg::NumW-1:0]     quo_q;
  logic [mmcs_pkg::PixW-1:0]     rem_q;
  logic [mmcs_pkg::PixW-1:0]     den_q;

  logic                          last_step;
  logic [mmcs_pkg::PixW:0]       rem_sh;
  logic                          fits;
  logic [mmcs_pkg::PixW:0]       rem_sub;
  logic [mmcs_pkg::PixW-1:0]     rem_nx;

  logic [mmcs_pkg::PixW:0]       rem_twice;
  logic                          round_up;
  logic [mmcs_pkg::NumW:0]       quo_rnd;

  // one quotient bit per cycle
  assign last_step = (step_q == mmcs_pkg::StepW'(mmcs_pkg::NumW - 1));
  assign rem_sh    = {rem_q, quo_q[mmcs_pkg::NumW-1]};
  assign fits      = (rem_sh >= {1'b0, den_q});
  assign rem_sub   = rem_sh - {1'b0, den_q};
  assign rem_nx    = fits ? rem_sub[mmcs_pkg::PixW-1:0] : rem_sh[mmcs_pkg::PixW-1:0];

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= busy_q && last_step;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + mmcs_pkg::StepW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[mmcs_pkg::NumW-2:0], fits};
      rem_q <= rem_nx;
    end
  end

  // round to nearest, ties to even, then clamp
  assign rem_twice = {rem_q, 1'b0};
  assign round_up  = (rem_twice > {1'b0, den_q}) ||
                     ((rem_twice == {1'b0, den_q}) && quo_q[0]);
  assign quo_rnd   = {1'b0, quo_q} + (mmcs_pkg::NumW + 1)'(round_up);

  always_comb begin
    rsp_o.done = fin_q;
    if (quo_rnd > {{(mmcs_pkg::NumW + 1 - mmcs_pkg::PixW){1'b0}}, mmcs_pkg::PixMax}) begin
      rsp_o.result = mmcs_pkg::PixMax;
    end else begin
      rsp_o.result = quo_rnd[mmcs_pkg::PixW-1:0];
    end
  end

endmodule

[design/min_max_contrast_stretch.sv]
// min_max_contrast_stretch: frame store with min/max tracking and stretched readout.
// Depends on mmcs_pkg, mmcs_ram (frame store) and mmcs_div (stretch divider).
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------
//   in      | in_valid_i / in_stall_o  | kind_i, pixel_in_i, frame_end_i
//   out     | out_valid_o / out_stall_i| pixel_out_o, last_out_o
//
// Loads can arrive on every cycle while no emit is in flight.
// An emit request reads the frame store (StRead), then runs the 16-step
// divider (StDiv); the result waits in StDone for the output register, and the
// next request is taken once the sequencer is back in StIdle.
// On a flat frame the divider is skipped and StDone passes 0 to the output
// register; an emit with nothing to return gives nothing.
// The input stalls while an emit is in flight or waits for the output register.
// Reset clears the frame state; the frame store itself is not cleared.
`timescale 1ns / 1ps

module min_max_contrast_stretch (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] pixel_in_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] pixel_out_o,
  output logic       last_out_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDiv,
    StDone
  } state_e;

  state_e                       state_q, state_d;
  logic [mmcs_pkg::CountW-1:0]  count_q, count_d;
  logic [mmcs_pkg::CountW-1:0]  rdptr_q, rdptr_d;
  logic [mmcs_pkg::PixW-1:0]    least_q, least_d;
  logic [mmcs_pkg::PixW-1:0]    great_q, great_d;
  logic                         ready_q, ready_d;
  logic                         last_q, last_d;
  logic [mmcs_pkg::PixW-1:0]    res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic [mmcs_pkg::PixW-1:0]    out_pix_q, out_pix_d;
  logic                         out_last_q, out_last_d;

  logic                         in_acc;
  logic [mmcs_pkg::CountW-1:0]  cnt_eff;
  logic [mmcs_pkg::PixW-1:0]    least_eff;
  logic [mmcs_pkg::PixW-1:0]    great_eff;
  logic                         ram_we;
  logic                         ram_re;
  logic [mmcs_pkg::PixW-1:0]    ram_rdata;
  logic                         flat;
  logic [mmcs_pkg::PixW-1:0]    diff;
  logic                         out_free;
  mmcs_pkg::div_req_t           div_req;
  mmcs_pkg::div_rsp_t           div_rsp;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  // a load after a closed frame starts a new frame
  assign cnt_eff   = ready_q ? '0 : count_q;
  assign least_eff = ready_q ? mmcs_pkg::PixMax : least_q;
  assign great_eff = ready_q ? mmcs_pkg::PixMin : great_q;

  assign ram_we = in_acc && !kind_i &&
                  (cnt_eff < mmcs_pkg::CountW'(mmcs_pkg::MaxPixels));
  assign ram_re = in_acc && kind_i && ready_q && (rdptr_q < count_q);

  // frame store
  mmcs_ram #(
    .Width (mmcs_pkg::PixW),
    .Depth (mmcs_pkg::MaxPixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_eff[mmcs_pkg::AddrW-1:0]),
    .wdata_i (pixel_in_i),
    .re_i    (ram_re),
    .raddr_i (rdptr_q[mmcs_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // numerator 255*(p-least) as shift and subtract
  assign flat = (great_q <= least_q) || (ram_rdata < least_q);
  assign diff = ram_rdata - least_q;

  always_comb begin
    div_req.start = (state_q == StRead) && !flat;
    div_req.num   = {diff, {mmcs_pkg::PixW{1'b0}}} - {{mmcs_pkg::PixW{1'b0}}, diff};
    div_req.den   = great_q - least_q;
  end

  mmcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer and frame bookkeeping
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rdptr_d     = rdptr_q;
    least_d     = least_q;
    great_d     = great_q;
    ready_d     = ready_q;
    last_d      = last_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc && !kind_i) begin
          count_d = cnt_eff;
          rdptr_d = ready_q ? '0 : rdptr_q;
          least_d = least_eff;
          great_d = great_eff;
          ready_d = 1'b0;
          if (ram_we) begin
            count_d = cnt_eff + mmcs_pkg::CountW'(1);
            if (pixel_in_i < least_eff) begin
              least_d = pixel_in_i;
            end
            if (pixel_in_i > great_eff) begin
              great_d = pixel_in_i;
            end
          end
          if (frame_end_i) begin
            ready_d = 1'b1;
            rdptr_d = '0;
          end
        end else if (ram_re) begin
          last_d  = (rdptr_q + mmcs_pkg::CountW'(1) == count_q);
          rdptr_d = rdptr_q + mmcs_pkg::CountW'(1);
          state_d = StRead;
        end
      end
      StRead: begin
        if (flat) begin
          res_d   = mmcs_pkg::PixMin;
          state_d = StDone;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.result;
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = res_q;
          out_last_d  = last_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rdptr_q     <= '0;
      least_q     <= mmcs_pkg::PixMax;
      great_q     <= mmcs_pkg::PixMin;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rdptr_q     <= rdptr_d;
      least_q     <= least_d;
      great_q     <= great_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    res_q      <= res_d;
    out_pix_q  <= out_pix_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign last_out_o  = out_last_q;

  // checks
  a_rdptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdptr_q <= count_q)
    else $error("read pointer ran past the pixel count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mmcs_pkg::CountW'(mmcs_pkg::MaxPixels))
    else $error("pixel count exceeds frame store capacity");

  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> least_q <= great_q)
    else $error("least value above greatest value with pixels stored");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StDiv)
    else $error("divider answered outside of the divide state");

  a_emit_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> rdptr_q == $past(rdptr_q) + mmcs_pkg::CountW'(1))
    else $error("emit did not advance the read pointer");

endmodule

[tb/sv/mmcs_tb_pkg.sv]
// mmcs_tb_pkg: request codes shared by the contrast stretch checker and test top.
// Depends on nothing.
`timescale 1ns / 1ps

package mmcs_tb_pkg;

  // what one input request asks for
  typedef enum logic {
    KindLoad = 1'b0,
    KindEmit = 1'b1
  } request_kind_e;

endpackage

[tb/sv/min_max_contrast_stretch_checker.sv]
// min_max_contrast_stretch_checker: watches both channels, predicts stretched pixels
// and compares them field by field. Depends on mmcs_pkg and mmcs_tb_pkg.
`timescale 1ns / 1ps

module min_max_contrast_stretch_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       kind_i,
  input  logic [7:0] pixel_in_i,
  input  logic       frame_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] pixel_out_i,
  input  logic       last_out_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [mmcs_pkg::PixW-1:0] pixel;
    logic                      last;
  } stretched_px_t;

  stretched_px_t             stretched_q[$];
  logic [mmcs_pkg::PixW-1:0] frame_mem[mmcs_pkg::MaxPixels];
  int unsigned               stored_count;
  int unsigned               read_idx;
  logic [mmcs_pkg::PixW-1:0] lo_seen;
  logic [mmcs_pkg::PixW-1:0] hi_seen;
  logic                      frame_closed;

  // empty frame state, as after reset or at the start of a new frame
  function automatic void clear_frame();
    stored_count = 0;
    read_idx     = 0;
    lo_seen      = mmcs_pkg::PixMax;
    hi_seen      = mmcs_pkg::PixMin;
    frame_closed = 1'b0;
  endfunction

  // round(255*(p-lo)/(hi-lo)), ties to even, saturated; flat frame gives 0
  function automatic logic [mmcs_pkg::PixW-1:0] stretch_pixel(
      logic [mmcs_pkg::PixW-1:0] p,
      logic [mmcs_pkg::PixW-1:0] lo,
      logic [mmcs_pkg::PixW-1:0] hi);
    int unsigned span;
    int unsigned scaled;
    int unsigned quo;
    int unsigned rem;
    if (hi <= lo || p < lo) return mmcs_pkg::PixMin;
    span   = int'(hi) - int'(lo);
    scaled = int'(mmcs_pkg::PixMax) * (int'(p) - int'(lo));
    quo    = scaled / span;
    rem    = scaled % span;
    if (2 * rem > span || (2 * rem == span && quo % 2 == 1)) quo++;
    return (quo > int'(mmcs_pkg::PixMax)) ? mmcs_pkg::PixMax : quo[mmcs_pkg::PixW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stretched_px_t want;
    if (!rst_ni) begin
      stretched_q.delete();
      clear_frame();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // compare an accepted result with the oldest expected one
      if (out_valid_i && !out_stall_i) begin
        if (stretched_q.size() == 0) begin
          $error("unexpected result: pixel_out %0d, last_out %0b", pixel_out_i, last_out_i);
          fail_count_o++;
        end else begin
          want = stretched_q.pop_front();
          if (pixel_out_i !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, pixel_out_i);
            fail_count_o++;
          end
          if (last_out_i !== want.last) begin
            $error("last_out: expected %0b, actual %0b", want.last, last_out_i);
            fail_count_o++;
          end
        end
      end

      // track the frame and predict the result of an accepted request
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == mmcs_tb_pkg::KindLoad) begin
          if (frame_closed) clear_frame();
          // pixels past capacity are dropped but their end flag still counts
          if (stored_count < mmcs_pkg::MaxPixels) begin
            frame_mem[stored_count] = pixel_in_i;
            stored_count++;
            if (pixel_in_i < lo_seen) lo_seen = pixel_in_i;
            if (pixel_in_i > hi_seen) hi_seen = pixel_in_i;
          end
          if (frame_end_i) begin
            frame_closed = 1'b1;
            read_idx     = 0;
          end
        end else if (frame_closed && read_idx < stored_count) begin
          want.pixel = stretch_pixel(frame_mem[read_idx], lo_seen, hi_seen);
          want.last  = (read_idx + 1 == stored_count);
          stretched_q.insert(stretched_q.size(), want);
          read_idx++;
        end
      end
      pending_o = stretched_q.size();
    end
  end

endmodule

[tb/sv/min_max_contrast_stretch_test.sv]
// min_max_contrast_stretch_test: drives loads and emit requests into the contrast
// stretch block with random gaps and stalls. Depends on the block, mmcs_tb_pkg
// and min_max_contrast_stretch_checker.
`timescale 1ns / 1ps

module min_max_contrast_stretch_test;

  localparam int CycleLimit  = 1500000;
  localparam int DrainCycles = 60;
  localparam int RandomItems = 1400;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       kind_i      = mmcs_tb_pkg::KindLoad;
  logic [7:0] pixel_in_i  = '0;
  logic       frame_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] pixel_out_o;
  logic       last_out_o;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   hold_left   = 0;
  logic idle_on     = 1'b1;
  int   items_sent  = 0;

  min_max_contrast_stretch dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .pixel_in_i  (pixel_in_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .last_out_o  (last_out_o)
  );

  min_max_contrast_stretch_checker stretch_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .pixel_in_i   (pixel_in_i),
    .frame_end_i  (frame_end_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_i  (pixel_out_o),
    .last_out_i   (last_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output side: hold each result for a random number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) hold_left = idle_on ? $urandom_range(0, 7) : 0;
      else if (out_valid_o && hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0);
    end
  end

  // one request: optional idle gap, then hold until accepted
  task automatic send_request(input mmcs_tb_pkg::request_kind_e k, input logic [7:0] p,
                              input logic fe);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    pixel_in_i  <= p;
    frame_end_i <= fe;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int frame_len;
    int emit_cnt;
    int lo;
    int hi;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // emit with no frame loaded gives nothing
    send_request(mmcs_tb_pkg::KindEmit, 8'hFF, 1'b1);

    // full range frame, then one emit past the end
    send_request(mmcs_tb_pkg::KindLoad, 8'd0, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd255, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd128, 1'b1);
    repeat (4) send_request(mmcs_tb_pkg::KindEmit, 8'h00, 1'b0);

    // span of 6: the middle pixel is a tie that rounds down to even
    send_request(mmcs_tb_pkg::KindLoad, 8'd10, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd16, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd11, 1'b1);
    repeat (3) send_request(mmcs_tb_pkg::KindEmit, 8'h5A, 1'b1);

    // flat frame
    send_request(mmcs_tb_pkg::KindLoad, 8'd77, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd77, 1'b1);
    repeat (2) send_request(mmcs_tb_pkg::KindEmit, 8'hA5, 1'b0);

    // single pixel frame
    send_request(mmcs_tb_pkg::KindLoad, 8'd200, 1'b1);
    send_request(mmcs_tb_pkg::KindEmit, 8'h00, 1'b0);

    // span of 2 with a tie pixel last; one emit reads the first pixel, then a new frame cuts the readout short
    send_request(mmcs_tb_pkg::KindLoad, 8'd0, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd2, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd1, 1'b1);
    send_request(mmcs_tb_pkg::KindEmit, 8'h00, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd30, 1'b0);
    send_request(mmcs_tb_pkg::KindLoad, 8'd10, 1'b1);
    repeat (2) send_request(mmcs_tb_pkg::KindEmit, 8'hFF, 1'b1);

    // random frames with random readout, plus bursts of unstructured requests
    while (items_sent < RandomItems) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_request(mmcs_tb_pkg::request_kind_e'($urandom_range(0, 1)), 8'($urandom),
                       1'($urandom));
      end else begin
        frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64)
                                                 : $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
          lo = 0;
          hi = 255;
        end else begin
          lo = $urandom_range(0, 255);
          hi = ($urandom_range(0, 7) == 0) ? lo : $urandom_range(lo, 255);
        end
        for (int i = 0; i < frame_len; i++) begin
          // stray emit while loading; before the first load it may still read out the last closed frame
          if ($urandom_range(0, 19) == 0)
            send_request(mmcs_tb_pkg::KindEmit, 8'($urandom), 1'($urandom));
          // now and then the end flag is missing and the frame runs on
          send_request(mmcs_tb_pkg::KindLoad, 8'($urandom_range(lo, hi)),
                       (i == frame_len - 1) && ($urandom_range(0, 11) != 0));
          items_sent++;
        end
        emit_cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, frame_len) : frame_len;
        repeat (emit_cnt) begin
          send_request(mmcs_tb_pkg::KindEmit, 8'($urandom), 1'($urandom));
          items_sent++;
        end
        repeat ($urandom_range(0, 2))
          send_request(mmcs_tb_pkg::KindEmit, 8'($urandom), 1'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then let any stray output show up
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[min_max_contrast_stretch.f]
design/mmcs_pkg.sv
design/mmcs_ram.sv
design/mmcs_div.sv
design/min_max_contrast_stretch.sv
tb/sv/mmcs_tb_pkg.sv
tb/sv/min_max_contrast_stretch_checker.sv
tb/sv/min_max_contrast_stretch_test.sv
